### rtl/core/smdu_pkg.sv
// smdu_pkg: item types, action codes and register offsets of the serial
// multiply/divide unit. No dependencies.
package smdu_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] reg_addr;
        logic [7:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       busy_res;
    } rsp_item_t;

    localparam logic [4:0] ADDR_MULT_A   = 5'd2;
    localparam logic [4:0] ADDR_MULT_B   = 5'd3;
    localparam logic [4:0] ADDR_DVND_LO  = 5'd4;
    localparam logic [4:0] ADDR_DVND_HI  = 5'd5;
    localparam logic [4:0] ADDR_DIVISOR  = 5'd6;
    localparam logic [4:0] ADDR_QUOT_LO  = 5'd20;
    localparam logic [4:0] ADDR_QUOT_HI  = 5'd21;
    localparam logic [4:0] ADDR_PROD_LO  = 5'd22;
    localparam logic [4:0] ADDR_PROD_HI  = 5'd23;

    localparam logic [3:0] MUL_STEPS = 4'd8;
    localparam logic [4:0] DIV_STEPS = 5'd16;

endpackage

### rtl/core/smdu_core.sv
// smdu_core: operand/result registers and the one-step shift-add and
// compare-subtract datapath. Depends on smdu_pkg.
module smdu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  smdu_pkg::req_item_t req,
    output smdu_pkg::rsp_item_t rsp
);

    logic [7:0]  multiplicand_reg, multiplicand_next;
    logic [15:0] dividend_reg, dividend_next;
    logic [15:0] quotient_reg, quotient_next;
    logic [15:0] prodrem_reg, prodrem_next;
    logic [23:0] shift_op_reg, shift_op_next;
    logic [3:0]  mul_left_reg, mul_left_next;
    logic [4:0]  div_left_reg, div_left_next;

    always_comb
    begin
        logic        busy;
        logic [23:0] shifted;
        multiplicand_next = multiplicand_reg;
        dividend_next     = dividend_reg;
        quotient_next     = quotient_reg;
        prodrem_next      = prodrem_reg;
        shift_op_next     = shift_op_reg;
        mul_left_next     = mul_left_reg;
        div_left_next     = div_left_reg;
        busy              = (mul_left_reg != 4'd0) || (div_left_reg != 5'd0);
        shifted           = {1'b0, shift_op_reg[23:1]};
        rsp.read_data     = 8'd0;

        case (req.action)
            smdu_pkg::ACT_WRITE:
            begin
                case (req.reg_addr)
                    smdu_pkg::ADDR_MULT_A: multiplicand_next = req.write_data;
                    smdu_pkg::ADDR_MULT_B:
                    begin
                        if (!busy)
                        begin
                            quotient_next = {req.write_data, multiplicand_reg};
                            prodrem_next  = 16'd0;
                            shift_op_next = {16'd0, req.write_data};
                            mul_left_next = smdu_pkg::MUL_STEPS;
                        end
                    end
                    smdu_pkg::ADDR_DVND_LO: dividend_next[7:0]  = req.write_data;
                    smdu_pkg::ADDR_DVND_HI: dividend_next[15:8] = req.write_data;
                    smdu_pkg::ADDR_DIVISOR:
                    begin
                        prodrem_next = dividend_reg;
                        if (!busy)
                        begin
                            shift_op_next = {req.write_data, 16'd0};
                            div_left_next = smdu_pkg::DIV_STEPS;
                        end
                    end
                    default: ;
                endcase
            end
            smdu_pkg::ACT_READ:
            begin
                case (req.reg_addr)
                    smdu_pkg::ADDR_QUOT_LO: rsp.read_data = quotient_reg[7:0];
                    smdu_pkg::ADDR_QUOT_HI: rsp.read_data = quotient_reg[15:8];
                    smdu_pkg::ADDR_PROD_LO: rsp.read_data = prodrem_reg[7:0];
                    smdu_pkg::ADDR_PROD_HI: rsp.read_data = prodrem_reg[15:8];
                    default:                rsp.read_data = 8'd0;
                endcase
            end
            smdu_pkg::ACT_TICK:
            begin
                // multiply and divide never run at once: each start needs idle
                if (mul_left_reg != 4'd0)
                begin
                    mul_left_next = mul_left_reg - 4'd1;
                    if (quotient_reg[0])
                        prodrem_next = prodrem_reg + shift_op_reg[15:0];
                    quotient_next = {1'b0, quotient_reg[15:1]};
                    shift_op_next = {shift_op_reg[22:0], 1'b0};
                end
                else if (div_left_reg != 5'd0)
                begin
                    div_left_next = div_left_reg - 5'd1;
                    shift_op_next = shifted;
                    if ({8'd0, prodrem_reg} >= shifted)
                    begin
                        prodrem_next  = prodrem_reg - shifted[15:0];
                        quotient_next = {quotient_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        quotient_next = {quotient_reg[14:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase

        rsp.busy_res = (mul_left_next != 4'd0) || (div_left_next != 5'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplicand_reg <= 8'hFF;
            dividend_reg     <= 16'hFFFF;
            quotient_reg     <= 16'd0;
            prodrem_reg      <= 16'd0;
            shift_op_reg     <= 24'd0;
            mul_left_reg     <= 4'd0;
            div_left_reg     <= 5'd0;
        end
        else if (step)
        begin
            multiplicand_reg <= multiplicand_next;
            dividend_reg     <= dividend_next;
            quotient_reg     <= quotient_next;
            prodrem_reg      <= prodrem_next;
            shift_op_reg     <= shift_op_next;
            mul_left_reg     <= mul_left_next;
            div_left_reg     <= div_left_next;
        end
    end

endmodule

### rtl/core/serial_multiply_divide_unit.sv
// serial_multiply_divide_unit: top level, handshake and result buffering
// around smdu_core. Depends on smdu_pkg and smdu_core.
// result items are registered; one item per cycle while the skid entry is empty;
// each tick item runs one multiply or divide step
// a two-entry output buffer (result register plus skid) keeps requests flowing
// while one result waits
// reset: asynchronous, active low; operands go to all ones, results and step
// counters to zero, the output buffer empties
module serial_multiply_divide_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  smdu_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output smdu_pkg::rsp_item_t rsp
);

    logic                accept;
    logic                pop;
    smdu_pkg::rsp_item_t core_rsp;

    logic                rsp_valid_reg;
    smdu_pkg::rsp_item_t rsp_reg;
    logic                skid_valid_reg;
    smdu_pkg::rsp_item_t skid_reg;

    // the skid entry is the only thing that can stop a request
    assign req_ready = !skid_valid_reg;
    assign accept    = req_valid && req_ready;
    assign pop       = rsp_valid_reg && rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // state advances on every taken item, the result is computed in the same pass
    smdu_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .req   (req),
        .rsp   (core_rsp)
    );

    // control of the two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no request taken here; drain skid into the result register
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!rsp_valid_reg || pop)
                rsp_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload of the output buffer, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                rsp_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (!rsp_valid_reg || pop)
                rsp_reg <= core_rsp;
            else
                skid_reg <= core_rsp;
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for serial_multiply_divide_unit, with its own
// model of the multiply/divide registers predicting every result item
// depends on smdu_pkg and serial_multiply_divide_unit
module tb_top;

    localparam int HALF_PERIOD     = 6;
    localparam int STALL_LIMIT     = 3000;
    localparam int ITEMS_PER_PHASE = 460;
    localparam int LONG_HOLD       = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int TAIL_CYCLES     = 20;

    // offsets that decode to no register
    localparam logic [4:0] ADDR_SPARE_LO = 5'd0;
    localparam logic [4:0] ADDR_SPARE_HI = 5'd31;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    smdu_pkg::req_item_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    smdu_pkg::rsp_item_t rsp;

    serial_multiply_divide_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------
    // model of the unit: operand bytes, result registers, step counters
    // all start at their reset values, reset is applied only once
    // ------------------------------------------------------------------
    logic [7:0]  mul_a   = 8'hFF;
    logic [7:0]  mul_b   = 8'hFF;
    logic [15:0] div_num = 16'hFFFF;
    logic [7:0]  div_den = 8'hFF;
    logic [15:0] quo_q   = '0;
    logic [15:0] acc_q   = '0;    // product during a multiply, remainder during a divide
    logic [23:0] shift_q = '0;    // shifted multiplier or divisor
    logic [3:0]  mul_cnt = '0;
    logic [4:0]  div_cnt = '0;

    // what the run went through
    int mul_starts     = 0;
    int div_starts     = 0;
    int zero_divs      = 0;
    int refused_starts = 0;

    function automatic logic unit_busy();
        return (mul_cnt != 0) || (div_cnt != 0);
    endfunction

    // one multiply step and/or one divide step
    task automatic run_step();
        if (mul_cnt != 0)
        begin
            mul_cnt = mul_cnt - 1'b1;
            if (quo_q[0])
                acc_q = acc_q + shift_q[15:0];
            quo_q   = quo_q >> 1;
            shift_q = shift_q << 1;
        end
        if (div_cnt != 0)
        begin
            div_cnt = div_cnt - 1'b1;
            quo_q   = quo_q << 1;
            shift_q = shift_q >> 1;
            // restoring compare on the full 24-bit width
            if ({8'd0, acc_q} >= shift_q)
            begin
                acc_q    = acc_q - shift_q[15:0];
                quo_q[0] = 1'b1;
            end
        end
    endtask

    // apply one request item to the model and return the result it gives
    task automatic step_unit(input smdu_pkg::req_item_t it, output smdu_pkg::rsp_item_t res);
        logic [7:0] rd;
        rd = '0;
        case (smdu_pkg::action_t'(it.action))
            smdu_pkg::ACT_WRITE:
            begin
                case (it.reg_addr)
                    smdu_pkg::ADDR_MULT_A:  mul_a = it.write_data;
                    smdu_pkg::ADDR_MULT_B:
                    begin
                        // the byte lands even when the start is refused
                        mul_b = it.write_data;
                        if (unit_busy())
                            refused_starts++;
                        else
                        begin
                            quo_q   = {mul_b, mul_a};
                            acc_q   = '0;
                            shift_q = {16'd0, mul_b};
                            mul_cnt = smdu_pkg::MUL_STEPS;
                            mul_starts++;
                        end
                    end
                    smdu_pkg::ADDR_DVND_LO: div_num[7:0]  = it.write_data;
                    smdu_pkg::ADDR_DVND_HI: div_num[15:8] = it.write_data;
                    smdu_pkg::ADDR_DIVISOR:
                    begin
                        // remainder reload happens even when busy
                        acc_q = div_num;
                        if (unit_busy())
                            refused_starts++;
                        else
                        begin
                            div_den = it.write_data;
                            shift_q = {div_den, 16'd0};
                            div_cnt = smdu_pkg::DIV_STEPS;
                            div_starts++;
                            if (div_den == 8'd0)
                                zero_divs++;
                        end
                    end
                    default: ;
                endcase
            end
            smdu_pkg::ACT_READ:
            begin
                case (it.reg_addr)
                    smdu_pkg::ADDR_QUOT_LO: rd = quo_q[7:0];
                    smdu_pkg::ADDR_QUOT_HI: rd = quo_q[15:8];
                    smdu_pkg::ADDR_PROD_LO: rd = acc_q[7:0];
                    smdu_pkg::ADDR_PROD_HI: rd = acc_q[15:8];
                    default:                rd = '0;
                endcase
            end
            smdu_pkg::ACT_TICK: run_step();
            default: ;
        endcase
        res.read_data = rd;
        res.busy_res  = unit_busy();
    endtask

    // ------------------------------------------------------------------
    // item queues and run controls
    // ------------------------------------------------------------------
    smdu_pkg::req_item_t pending_items[$];
    smdu_pkg::rsp_item_t expected_rsp[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int mismatches     = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_requests  = 0;    // bumped by the sequence, served by the receiver
    int hold_done      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    task automatic queue_item(input smdu_pkg::action_t act, input logic [4:0] addr,
                              input logic [7:0] data);
        smdu_pkg::req_item_t it;
        it.action     = act;
        it.reg_addr   = addr;
        it.write_data = data;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // operand bytes lean toward the corners
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ticks with result reads scattered in, so partial values get checked
    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 25)
                queue_item(smdu_pkg::ACT_READ,
                           smdu_pkg::ADDR_QUOT_LO + 5'($urandom_range(3)),
                           8'($urandom_range(255)));
            queue_item(smdu_pkg::ACT_TICK, 5'($urandom_range(31)),
                       8'($urandom_range(255)));
        end
    endtask

    task automatic queue_results();
        for (int k = 0; k < 4; k++)
            queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_QUOT_LO + 5'(k),
                       8'($urandom_range(255)));
    endtask

    // short tick runs leave the unit busy, so the next start gets refused
    task automatic queue_multiply();
        if ($urandom_range(3) != 0)
            queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_MULT_A, pick_operand());
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_MULT_B, pick_operand());
        if ($urandom_range(3) == 0)
            queue_ticks($urandom_range(smdu_pkg::MUL_STEPS + 3));
        else
            queue_ticks(smdu_pkg::MUL_STEPS);
        queue_results();
    endtask

    task automatic queue_divide();
        if ($urandom_range(3) != 0)
            queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_DVND_LO, pick_operand());
        if ($urandom_range(3) != 0)
            queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_DVND_HI, pick_operand());
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_DIVISOR,
                   ($urandom_range(7) == 0) ? 8'h00 : pick_operand());
        if ($urandom_range(3) == 0)
            queue_ticks($urandom_range(smdu_pkg::DIV_STEPS + 3));
        else
            queue_ticks(smdu_pkg::DIV_STEPS);
        queue_results();
    endtask

    // any action at any offset
    task automatic queue_noise();
        int n;
        n = $urandom_range(6, 1);
        repeat (n)
            queue_item(smdu_pkg::action_t'($urandom_range(3)), 5'($urandom_range(31)),
                       8'($urandom_range(255)));
    endtask

    task automatic queue_phase(input int count);
        int first;
        first = queued_count;
        while (queued_count - first < count)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: queue_multiply();
                4, 5, 6, 7: queue_divide();
                default:    queue_noise();
            endcase
        end
    endtask

    task automatic queue_directed();
        // result registers right after reset
        queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_QUOT_LO, 8'h00);
        queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_PROD_HI, 8'hFF);
        // largest product, with a multiplier write while busy in between
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_MULT_A, 8'hFF);
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_MULT_B, 8'hFF);
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_MULT_B, 8'h00);
        repeat (smdu_pkg::MUL_STEPS)
            queue_item(smdu_pkg::ACT_TICK, ADDR_SPARE_HI, 8'hFF);
        queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_PROD_LO, 8'h00);
        queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_PROD_HI, 8'h00);
        // divide by zero on the reset dividend, then a divisor write while busy
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_DIVISOR, 8'h00);
        queue_item(smdu_pkg::ACT_WRITE, smdu_pkg::ADDR_DIVISOR, 8'h05);
        // no-op action, unused offsets, partial reads mid divide
        queue_item(smdu_pkg::ACT_NOP, ADDR_SPARE_HI, 8'hAA);
        queue_item(smdu_pkg::ACT_WRITE, ADDR_SPARE_HI, 8'h55);
        queue_item(smdu_pkg::ACT_READ, ADDR_SPARE_LO, 8'h00);
        repeat (4)
            queue_item(smdu_pkg::ACT_TICK, ADDR_SPARE_LO, 8'h00);
        queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_QUOT_HI, 8'h00);
        queue_item(smdu_pkg::ACT_READ, smdu_pkg::ADDR_PROD_LO, 8'h00);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || req_valid)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: offers the next pending item, predicts each one taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_items
        smdu_pkg::rsp_item_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                step_unit(req, want);
                expected_rsp.push_back(want);
                accepted_count++;
            end
            // only move on once the current item is gone
            if (!req_valid || req_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    req       <= pending_items.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result item against the oldest prediction
    // and drives rsp_ready, including the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : collect_results
        smdu_pkg::rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                checked_count++;
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result item with none expected: read_data=%h busy=%b",
                                 $realtime, rsp.read_data, rsp.busy_res);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_data !== want.read_data || rsp.busy_res !== want.busy_res)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: result %0d: read_data exp %h got %h, busy exp %b got %b",
                                     $realtime, checked_count, want.read_data, rsp.read_data,
                                     want.busy_res, rsp.busy_res);
                    end
                end
            end
            // long hold-off so the output buffer fills and the input stalls
            if (hold_done < hold_requests)
            begin
                hold_left = LONG_HOLD;
                hold_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, expected_rsp.size());
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed items, then three random phases with
    // different idle patterns on each side
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalling
        tx_idle_pct = 20;
        rx_idle_pct = 88;
        queue_directed();
        queue_phase(ITEMS_PER_PHASE);
        wait_drained();

        // sender sparse, receiver mostly ready
        tx_idle_pct = 88;
        rx_idle_pct = 20;
        queue_phase(ITEMS_PER_PHASE);
        wait_drained();

        // full rate on both sides, opened by one long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_phase(ITEMS_PER_PHASE);
        hold_requests++;
        wait_drained();

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d items in, %0d results checked; %0d multiplies, %0d divides",
                 accepted_count, checked_count, mul_starts, div_starts);
        $display("run: %0d divides by zero, %0d starts refused while busy, %0d mismatches",
                 zero_divs, refused_starts, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
